// ===== rtl/density_rank_point_filter_defines.svh =====
// Assertion shorthands for the point filter. All of them sample on clk and
// are switched off while rst is high.
`ifndef DENSITY_RANK_POINT_FILTER_DEFINES_SVH
`define DENSITY_RANK_POINT_FILTER_DEFINES_SVH

// The condition holds at every edge.
`define DRPF_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define DRPF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define DRPF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/drpf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package drpf_pkg;

  localparam int TEX_DIM_MAX_DEF = 256;

  localparam int COORD_W  = 17;
  localparam int INDEX_W  = 16;
  localparam int GRAY_W   = 8;
  localparam int RANK_W   = 16;
  localparam int FACTOR_W = 32;
  localparam int SIZE_W   = 9;

  localparam int ONE_Q16    = 65536;
  localparam int FRAC_SHIFT = 16;

  localparam int PROD_W   = COORD_W + SIZE_W;
  localparam int CELL_W   = PROD_W - FRAC_SHIFT;
  localparam int BASE_W   = CELL_W + SIZE_W + 1;
  localparam int FRAC_W   = FRAC_SHIFT + 2;
  localparam int WEIGHT_W = FRAC_W + 1;
  localparam int P1_W     = GRAY_W + 1 + WEIGHT_W;
  localparam int P2_W     = P1_W + WEIGHT_W;
  localparam int ACC_W    = P2_W + 2;
  localparam int RPROD_W  = RANK_W + FACTOR_W;
  localparam int THR_W    = RPROD_W + 8;
  localparam int CMP_W    = THR_W + 2;

  localparam int RES_DEPTH = 8;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TEST = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CLIP_MIN_X = 3'd0,
    CFG_CLIP_MAX_X = 3'd1,
    CFG_CLIP_MIN_Y = 3'd2,
    CFG_CLIP_MAX_Y = 3'd3,
    CFG_RANK_FACTOR = 3'd4,
    CFG_TEX_SIZE = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT = 2'd0,
    VERDICT_CLIP = 2'd1,
    VERDICT_RANK = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
    verdict_t verdict;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/density_rank_point_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Signals                               Item
// s_axis   in         tvalid tready tdata[79:0] tuser[0]    texel load or point test
// m_axis   out        tvalid tready tdata[39:0]             point verdict
// cfg      in         valid ready index[2:0] data[31:0]     register write
//
// A texel load uses the texture port and gives no result.
// A point inside the clip window makes four texel reads through the single port
// of the texture memory; a clipped point makes none.
// Every test item, inside or clipped, gives one result from stage G.
// Reset clears the control state only; the texture needs no clearing pass.
// Results wait in an eight-entry queue; a point waits at the texture port while eight are owed.

`include "density_rank_point_filter_defines.svh"

module density_rank_point_filter
  import drpf_pkg::*;
#(
  parameter int TEX_DIM_MAX = TEX_DIM_MAX_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  // texel_index[15:0], texel_gray[23:16], point_x[40:24], point_y[57:41], rank[73:58]
  input  wire [IN_TDATA_W-1:0]   s_axis_tdata,
  // mode[0]
  input  wire                    s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  // verdict[1:0], out_x[18:2], out_y[35:19]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire [CFG_INDEX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0]   cfg_data
);

  localparam int TEX_DEPTH = TEX_DIM_MAX * TEX_DIM_MAX;
  localparam int AW        = $clog2(TEX_DEPTH);
  localparam int PTR_W     = $clog2(RES_DEPTH);
  localparam int CNT_W     = $clog2(RES_DEPTH + 1);

  // Configuration registers.
  logic [COORD_W-1:0]  clip_min_x, clip_max_x, clip_min_y, clip_max_y;
  logic [FACTOR_W-1:0] rank_factor;
  logic [SIZE_W-1:0]   tex_size;
  logic [SIZE_W-1:0]   eff_size;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_min_x  <= '0;
      clip_max_x  <= COORD_W'(ONE_Q16);
      clip_min_y  <= '0;
      clip_max_y  <= COORD_W'(ONE_Q16);
      rank_factor <= '0;
      tex_size    <= SIZE_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CLIP_MIN_X:  clip_min_x  <= cfg_data[COORD_W-1:0];
        CFG_CLIP_MAX_X:  clip_max_x  <= cfg_data[COORD_W-1:0];
        CFG_CLIP_MIN_Y:  clip_min_y  <= cfg_data[COORD_W-1:0];
        CFG_CLIP_MAX_Y:  clip_max_y  <= cfg_data[COORD_W-1:0];
        CFG_RANK_FACTOR: rank_factor <= cfg_data[FACTOR_W-1:0];
        CFG_TEX_SIZE:    tex_size    <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tex_size < SIZE_W'(2)) begin
      eff_size = SIZE_W'(2);
    end else if (32'(tex_size) > 32'(TEX_DIM_MAX)) begin
      eff_size = SIZE_W'(TEX_DIM_MAX);
    end else begin
      eff_size = tex_size;
    end
  end

  // Stage A: the accepted item as it arrived.
  logic                a_valid, a_ready;
  logic                a_mode;
  logic [INDEX_W-1:0]  a_idx;
  logic [GRAY_W-1:0]   a_gray;
  logic [COORD_W-1:0]  a_px, a_py;
  logic [RANK_W-1:0]   a_rank;

  // Stage B: scaled coordinates, clip test and rank product.
  logic                b_valid, b_ready;
  logic                b_mode, b_inside;
  logic [INDEX_W-1:0]  b_idx;
  logic [GRAY_W-1:0]   b_gray;
  logic [COORD_W-1:0]  b_px, b_py;
  logic [PROD_W-1:0]   b_tx, b_ty;
  logic [RPROD_W-1:0]  b_rprod;

  // Stage C: cell base address, weights and threshold.
  logic                       c_valid, c_ready;
  logic                       c_mode, c_inside;
  logic [INDEX_W-1:0]         c_idx;
  logic [GRAY_W-1:0]          c_gray;
  logic [COORD_W-1:0]         c_px, c_py;
  logic [BASE_W-1:0]          c_base;
  logic signed [WEIGHT_W-1:0] c_fx, c_fy, c_wx0, c_wy0;
  logic [THR_W-1:0]           c_thr;

  // Stage D: owns the texture port, at most one access per cycle; a point start waits for a result credit.
  logic                       d_valid, d_ready;
  logic                       d_mode, d_inside;
  logic [1:0]                 d_phase;
  logic [INDEX_W-1:0]         d_idx;
  logic [GRAY_W-1:0]          d_gray;
  logic [COORD_W-1:0]         d_px, d_py;
  logic [BASE_W-1:0]          d_base;
  logic signed [WEIGHT_W-1:0] d_fx, d_fy, d_wx0, d_wy0;
  logic [THR_W-1:0]           d_thr;

  assign a_ready       = !a_valid || b_ready;
  assign b_ready       = !b_valid || c_ready;
  assign c_ready       = !c_valid || d_ready;
  assign s_axis_tready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_mode <= s_axis_tuser;
      a_idx  <= s_axis_tdata[15:0];
      a_gray <= s_axis_tdata[23:16];
      a_px   <= s_axis_tdata[40:24];
      a_py   <= s_axis_tdata[57:41];
      a_rank <= s_axis_tdata[73:58];
    end
  end

  // Sampling saturates coordinates at one; clipping uses the raw value.
  logic [COORD_W-1:0] a_cx, a_cy;
  logic               a_inside;

  always_comb begin
    a_cx     = (a_px > COORD_W'(ONE_Q16)) ? COORD_W'(ONE_Q16) : a_px;
    a_cy     = (a_py > COORD_W'(ONE_Q16)) ? COORD_W'(ONE_Q16) : a_py;
    a_inside = (a_px >= clip_min_x) && (a_px <= clip_max_x) &&
               (a_py >= clip_min_y) && (a_py <= clip_max_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_mode   <= a_mode;
      b_inside <= a_inside;
      b_idx    <= a_idx;
      b_gray   <= a_gray;
      b_px     <= a_px;
      b_py     <= a_py;
      b_tx     <= PROD_W'(a_cx) * PROD_W'(eff_size);
      b_ty     <= PROD_W'(a_cy) * PROD_W'(eff_size);
      b_rprod  <= RPROD_W'(a_rank) * RPROD_W'(rank_factor);
    end
  end

  // The cell is clamped to size-2, so the fraction can reach two at the edge.
  logic [CELL_W-1:0]          cell_lim, ix_raw, iy_raw, ix_cl, iy_cl;
  logic [PROD_W-1:0]          fx_full, fy_full;
  logic signed [WEIGHT_W-1:0] fx_c, fy_c;

  always_comb begin
    cell_lim = CELL_W'(eff_size) - CELL_W'(2);
    ix_raw   = b_tx[PROD_W-1:FRAC_SHIFT];
    iy_raw   = b_ty[PROD_W-1:FRAC_SHIFT];
    ix_cl    = (ix_raw > cell_lim) ? cell_lim : ix_raw;
    iy_cl    = (iy_raw > cell_lim) ? cell_lim : iy_raw;
    fx_full  = b_tx - {ix_cl, {FRAC_SHIFT{1'b0}}};
    fy_full  = b_ty - {iy_cl, {FRAC_SHIFT{1'b0}}};
    fx_c     = $signed({1'b0, fx_full[FRAC_W-1:0]});
    fy_c     = $signed({1'b0, fy_full[FRAC_W-1:0]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready) begin
      c_mode   <= b_mode;
      c_inside <= b_inside;
      c_idx    <= b_idx;
      c_gray   <= b_gray;
      c_px     <= b_px;
      c_py     <= b_py;
      c_base   <= BASE_W'(iy_cl) * BASE_W'(eff_size) + BASE_W'(ix_cl);
      c_fx     <= fx_c;
      c_fy     <= fy_c;
      c_wx0    <= $signed(WEIGHT_W'(ONE_Q16)) - fx_c;
      c_wy0    <= $signed(WEIGHT_W'(ONE_Q16)) - fy_c;
      c_thr    <= (THR_W'(b_rprod) << 8) - THR_W'(b_rprod);
    end
  end

  // Result credits: a test item starts only when its queue slot is reserved.
  logic [CNT_W-1:0] res_credit;
  logic [CNT_W-1:0] res_count;
  logic             res_push, res_pop;

  logic              d_load, d_start, d_last, d_go, d_done, d_idx_ok;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_addr;
  logic [BASE_W-1:0] rd_sum, idx_ext;
  logic [GRAY_W-1:0] mem_wdata;

  always_comb begin
    d_load    = (d_mode == MODE_LOAD);
    d_start   = (d_phase == 2'd0);
    d_last    = d_load || !d_inside || (d_phase == 2'd3);
    d_go      = d_valid && (d_load || !d_start || (res_credit < CNT_W'(RES_DEPTH)));
    d_done    = d_go && d_last;
    d_ready   = !d_valid || d_done;
    d_idx_ok  = 32'(d_idx) < 32'(TEX_DEPTH);
    idx_ext   = BASE_W'(d_idx);
    rd_sum    = d_base + (d_phase[1] ? BASE_W'(eff_size) : BASE_W'(0)) +
                BASE_W'(d_phase[0]);
    mem_we    = d_go && d_load && d_idx_ok;
    mem_re    = d_go && !d_load && d_inside;
    mem_addr  = d_load ? idx_ext[AW-1:0] : rd_sum[AW-1:0];
    mem_wdata = 8'd255 - d_gray;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      d_phase <= 2'd0;
    end else begin
      if (d_go) begin
        d_phase <= d_last ? 2'd0 : d_phase + 2'd1;
      end
      if (d_ready) begin
        d_valid <= c_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready) begin
      d_mode   <= c_mode;
      d_inside <= c_inside;
      d_idx    <= c_idx;
      d_gray   <= c_gray;
      d_px     <= c_px;
      d_py     <= c_py;
      d_base   <= c_base;
      d_fx     <= c_fx;
      d_fy     <= c_fy;
      d_wx0    <= c_wx0;
      d_wy0    <= c_wy0;
      d_thr    <= c_thr;
    end
  end

  // Density texture, one port, registered read data.
  logic [GRAY_W-1:0] tex_mem [TEX_DEPTH];
  logic [GRAY_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tex_mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rd_data <= tex_mem[mem_addr];
    end
  end

  // Stage E: texel arrives, weighted by the x weight.
  logic                       e_valid, e_sampled, e_last;
  logic [1:0]                 e_phase;
  logic signed [WEIGHT_W-1:0] e_wx, e_wy;
  logic [THR_W-1:0]           e_thr;
  logic [COORD_W-1:0]         e_px, e_py;
  logic signed [P1_W-1:0]     e_p1;

  // Stage F: weighted by the y weight.
  logic                       f_valid, f_sampled, f_last;
  logic [1:0]                 f_phase;
  logic signed [P1_W-1:0]     f_p1;
  logic signed [WEIGHT_W-1:0] f_wy;
  logic [THR_W-1:0]           f_thr;
  logic [COORD_W-1:0]         f_px, f_py;

  // Stage G: accumulate the four corners and decide.
  logic                       g_valid, g_sampled, g_last;
  logic [1:0]                 g_phase;
  logic signed [P2_W-1:0]     g_p2;
  logic [THR_W-1:0]           g_thr;
  logic [COORD_W-1:0]         g_px, g_py;
  logic signed [ACC_W-1:0]    acc, acc_sum;
  result_t                    g_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      g_valid <= 1'b0;
    end else begin
      e_valid <= d_go && !d_load;
      f_valid <= e_valid;
      g_valid <= f_valid;
    end
  end

  assign e_p1 = $signed({1'b0, rd_data}) * e_wx;

  always_ff @(posedge clk) begin
    e_sampled <= d_inside;
    e_last    <= d_last;
    e_phase   <= d_phase;
    e_wx      <= d_phase[0] ? d_fx : d_wx0;
    e_wy      <= d_phase[1] ? d_fy : d_wy0;
    e_thr     <= d_thr;
    e_px      <= d_px;
    e_py      <= d_py;

    f_sampled <= e_sampled;
    f_last    <= e_last;
    f_phase   <= e_phase;
    f_p1      <= e_p1;
    f_wy      <= e_wy;
    f_thr     <= e_thr;
    f_px      <= e_px;
    f_py      <= e_py;

    g_sampled <= f_sampled;
    g_last    <= f_last;
    g_phase   <= f_phase;
    g_p2      <= f_p1 * f_wy;
    g_thr     <= f_thr;
    g_px      <= f_px;
    g_py      <= f_py;

    if (g_valid && g_sampled) begin
      acc <= acc_sum;
    end
  end

  always_comb begin
    acc_sum    = ((g_phase == 2'd0) ? ACC_W'(0) : acc) + ACC_W'(g_p2);
    g_result.x = g_px;
    g_result.y = g_py;
    if (!g_sampled) begin
      g_result.verdict = VERDICT_CLIP;
    end else if ($signed(CMP_W'(acc_sum)) < $signed({2'b00, g_thr})) begin
      g_result.verdict = VERDICT_RANK;
    end else begin
      g_result.verdict = VERDICT_ACCEPT;
    end
  end

  // Result queue.
  result_t          res_fifo [RES_DEPTH];
  logic [PTR_W-1:0] res_wr_ptr, res_rd_ptr;

  assign res_push      = g_valid && g_last;
  assign res_pop       = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (res_count != CNT_W'(0));
  assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, res_fifo[res_rd_ptr]};

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_fifo[res_wr_ptr] <= g_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr_ptr <= '0;
      res_rd_ptr <= '0;
      res_count  <= '0;
      res_credit <= '0;
    end else begin
      if (res_push) begin
        res_wr_ptr <= res_wr_ptr + PTR_W'(1);
      end
      if (res_pop) begin
        res_rd_ptr <= res_rd_ptr + PTR_W'(1);
      end
      res_count  <= res_count + CNT_W'(res_push) - CNT_W'(res_pop);
      res_credit <= res_credit + CNT_W'(d_go && !d_load && d_start) - CNT_W'(res_pop);
    end
  end

  `DRPF_ASSERT_NOW(a_credit_bound, res_credit <= CNT_W'(RES_DEPTH), "result credits overrun")
  `DRPF_ASSERT_NOW(a_queue_within_credit, res_count <= res_credit, "queue holds uncredited item")
  `DRPF_ASSERT_IMP(a_push_has_room, res_push, (res_count < CNT_W'(RES_DEPTH)) || res_pop, "push into full result queue")
  `DRPF_ASSERT_NXT(a_read_feeds_tail, mem_re, e_valid && e_sampled, "texel read without tail slot")
  `DRPF_ASSERT_NXT(a_corner_order, g_valid && g_sampled && !g_last, g_valid && g_sampled && (g_phase == $past(g_phase) + 2'd1), "corner accumulation out of order")

endmodule

`default_nettype wire
